// ===== design/top_n_sorted_insert_macros.svh =====
// ---------------------------------------------------------------------------
// top_n_sorted_insert assertion macros
// shared concurrent assertion forms for the sorted score table
// ---------------------------------------------------------------------------
`ifndef TOP_N_SORTED_INSERT_MACROS_SVH
`define TOP_N_SORTED_INSERT_MACROS_SVH

// overlapping implication, checked outside reset
`define TNSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TNSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tnsi_pkg.sv =====
// ---------------------------------------------------------------------------
// tnsi_pkg
// shared sizes and the link type passed between neighbouring table cells
// ---------------------------------------------------------------------------
package tnsi_pkg;

    localparam int ENTRIES    = 8;
    localparam int TAG_BITS   = 16;
    localparam int SCORE_BITS = 32;
    localparam int IDX_BITS   = 3;
    localparam int CNT_BITS   = 4;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic                  ge;
        logic [SCORE_BITS-1:0] score;
        logic [TAG_BITS-1:0]   tag;
    } t_link;

endpackage

// ===== design/top_n_sorted_insert.sv =====
// ---------------------------------------------------------------------------
// top_n_sorted_insert
// descending table of the best scores with player tags, built as a chain of
// cells; inserts keep ties in arrival order, reads return one entry
// ---------------------------------------------------------------------------
//  channel   | handshake          | payload
//  request   | start / busy       | i_mode, i_player_tag, i_new_score, i_read_index
//  result    | o_strobe           | o_inserted, o_insert_position, o_entry_count,
//            |                    | o_read_valid, o_read_tag, o_read_score
//
//  one request per cycle; busy is never raised
//  the result strobes in the cycle after the request, from the output register
//  every cell compares and shifts in the same cycle
//  reset clears the cell valid bits and the entry count
//  the receiver cannot stall; each result is shown for one cycle only
// ---------------------------------------------------------------------------
`include "top_n_sorted_insert_macros.svh"

module top_n_sorted_insert
    import tnsi_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [TAG_BITS-1:0]          i_player_tag,
    input  logic signed [SCORE_BITS-1:0] i_new_score,
    input  logic [IDX_BITS-1:0]          i_read_index,
    output logic                         o_strobe,
    output logic                         o_inserted,
    output logic [IDX_BITS-1:0]          o_insert_position,
    output logic [CNT_BITS-1:0]          o_entry_count,
    output logic                         o_read_valid,
    output logic [TAG_BITS-1:0]          o_read_tag,
    output logic signed [SCORE_BITS-1:0] o_read_score
);

    t_link                 w_link [ENTRIES+1];
    logic [ENTRIES-1:0]    w_ge;
    logic [ENTRIES-1:0]    w_valid;
    logic                  w_ins;
    logic [CNT_BITS-1:0]   w_pos;
    logic                  w_fits;

    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    logic                  r_strobe;
    logic                  r_inserted;
    logic                  n_inserted;
    logic [IDX_BITS-1:0]   r_position;
    logic [IDX_BITS-1:0]   n_position;
    logic                  r_read_valid;
    logic                  n_read_valid;
    logic [TAG_BITS-1:0]   r_read_tag;
    logic [TAG_BITS-1:0]   n_read_tag;
    logic [SCORE_BITS-1:0] r_read_score;
    logic [SCORE_BITS-1:0] n_read_score;

    assign busy  = 1'b0;
    assign w_ins = start && !busy && (i_mode == MODE_INSERT);

    // head of the chain: a virtual entry above slot zero that always wins
    assign w_link[0].valid = 1'b0;
    assign w_link[0].ge    = 1'b1;
    assign w_link[0].score = '0;
    assign w_link[0].tag   = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            tnsi_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ins       (w_ins),
                .i_new_score (i_new_score),
                .i_new_tag   (i_player_tag),
                .i_prev      (w_link[g]),
                .o_link      (w_link[g+1])
            );
            assign w_ge[g]    = w_link[g+1].ge;
            assign w_valid[g] = w_link[g+1].valid;
        end
    endgenerate

    // ge bits form a prefix of ones, so their count is the slot
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_pos = w_pos + CNT_BITS'(w_ge[k]);
        end
    end

    assign w_fits = !w_ge[ENTRIES-1];

    always_comb begin
        n_count      = r_count;
        n_inserted   = 1'b0;
        n_position   = '0;
        n_read_valid = 1'b0;
        n_read_tag   = '0;
        n_read_score = '0;
        case (i_mode)
            MODE_INSERT: begin
                if (w_fits) begin
                    n_inserted = 1'b1;
                    n_position = w_pos[IDX_BITS-1:0];
                    if (r_count < CNT_BITS'(ENTRIES)) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            MODE_READ: begin
                if ({1'b0, i_read_index} < r_count) begin
                    n_read_valid = 1'b1;
                    n_read_tag   = w_link[CNT_BITS'(i_read_index) + CNT_BITS'(1)].tag;
                    n_read_score = w_link[CNT_BITS'(i_read_index) + CNT_BITS'(1)].score;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= start && !busy;
            if (start && !busy) begin
                r_count <= n_count;
            end
        end
        r_inserted   <= n_inserted;
        r_position   <= n_position;
        r_read_valid <= n_read_valid;
        r_read_tag   <= n_read_tag;
        r_read_score <= n_read_score;
    end

    assign o_strobe          = r_strobe;
    assign o_inserted        = r_inserted;
    assign o_insert_position = r_position;
    assign o_entry_count     = r_count;
    assign o_read_valid      = r_read_valid;
    assign o_read_tag        = r_read_tag;
    assign o_read_score      = r_read_score;

    `TNSI_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_strobe, "missing result")
    `TNSI_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, $countones(w_valid) == r_count, "count and valid bits disagree")
    `TNSI_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, o_strobe && o_inserted, {1'b0, o_insert_position} < o_entry_count, "insert position beyond count")
    `TNSI_ASSERT_IMP(a_read_excl, i_clk, i_rst_n, o_strobe && o_read_valid, !o_inserted, "read and insert both flagged")

endmodule

// ===== design/tnsi_cell.sv =====
// ---------------------------------------------------------------------------
// tnsi_cell
// one table slot: compares against the incoming score, then keeps its entry,
// takes the new entry, or takes its upper neighbour's entry
// ---------------------------------------------------------------------------
module tnsi_cell
    import tnsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ins,
    input  logic [SCORE_BITS-1:0] i_new_score,
    input  logic [TAG_BITS-1:0]   i_new_tag,
    input  t_link                 i_prev,
    output t_link                 o_link
);

    logic                  r_valid;
    logic [SCORE_BITS-1:0] r_score;
    logic [TAG_BITS-1:0]   r_tag;
    logic                  n_valid;
    logic [SCORE_BITS-1:0] n_score;
    logic [TAG_BITS-1:0]   n_tag;
    logic                  w_ge;

    assign w_ge = r_valid && ($signed(r_score) >= $signed(i_new_score));

    always_comb begin
        n_valid = r_valid;
        n_score = r_score;
        n_tag   = r_tag;
        if (i_ins && !w_ge) begin
            if (i_prev.ge) begin
                n_valid = 1'b1;
                n_score = i_new_score;
                n_tag   = i_new_tag;
            end else begin
                n_valid = i_prev.valid;
                n_score = i_prev.score;
                n_tag   = i_prev.tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_score <= n_score;
        r_tag   <= n_tag;
    end

    assign o_link.valid = r_valid;
    assign o_link.ge    = w_ge;
    assign o_link.score = r_score;
    assign o_link.tag   = r_tag;

endmodule

// ===== dv/tnsi_score_checker.sv =====
// ---------------------------------------------------------------------------
// tnsi_score_checker
// watches the request and result channels of the score table, keeps its own
// ranked board of scores and tags, and compares every result field with the
// reply that the board predicts for the oldest outstanding request
// ---------------------------------------------------------------------------
module tnsi_score_checker
    import tnsi_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic                         i_mode,
    input  logic [TAG_BITS-1:0]          i_player_tag,
    input  logic signed [SCORE_BITS-1:0] i_new_score,
    input  logic [IDX_BITS-1:0]          i_read_index,
    input  logic                         i_strobe,
    input  logic                         i_inserted,
    input  logic [IDX_BITS-1:0]          i_insert_position,
    input  logic [CNT_BITS-1:0]          i_entry_count,
    input  logic                         i_read_valid,
    input  logic [TAG_BITS-1:0]          i_read_tag,
    input  logic signed [SCORE_BITS-1:0] i_read_score,
    output int                           o_fail_count,
    output int                           o_replies_due
);

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic                  inserted;
        logic [IDX_BITS-1:0]   position;
        logic [CNT_BITS-1:0]   count;
        logic                  read_valid;
        logic [TAG_BITS-1:0]   read_tag;
        logic [SCORE_BITS-1:0] read_score;
    } t_reply;

    logic signed [SCORE_BITS-1:0] board_score [ENTRIES];
    logic [TAG_BITS-1:0]          board_tag   [ENTRIES];
    int                           board_count;
    t_reply                       replies_due [$];
    int                           fail_total;
    int                           reply_no;

    initial begin
        board_count   = 0;
        fail_total    = 0;
        reply_no      = 0;
        o_fail_count  = 0;
        o_replies_due = 0;
    end

    // place a new score after every entry at or above it, or fetch one entry
    function automatic t_reply rank_request(input logic                         mode,
                                            input logic [TAG_BITS-1:0]          tag,
                                            input logic signed [SCORE_BITS-1:0] score,
                                            input logic [IDX_BITS-1:0]          idx);
        t_reply r;
        int     slot;
        int     last;
        int     k;
        r = '0;
        if (mode == MODE_INSERT) begin
            slot = 0;
            for (k = 0; k < board_count; k++) begin
                if (board_score[k] >= score)
                    slot++;
            end
            if (slot < ENTRIES) begin
                last = (board_count < ENTRIES) ? board_count : ENTRIES - 1;
                for (k = last; k > slot; k--) begin
                    board_score[k] = board_score[k-1];
                    board_tag[k]   = board_tag[k-1];
                end
                board_score[slot] = score;
                board_tag[slot]   = tag;
                if (board_count < ENTRIES)
                    board_count++;
                r.inserted = 1'b1;
                r.position = IDX_BITS'(slot);
            end
        end else begin
            if (int'(idx) < board_count) begin
                r.read_valid = 1'b1;
                r.read_tag   = board_tag[idx];
                r.read_score = board_score[idx];
            end
        end
        r.count = CNT_BITS'(board_count);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] seen,
                                 input logic [63:0] want);
        fail_total++;
        if (fail_total <= PRINT_CAP)
            $display("mismatch on result %0d, %s: got 0x%0h, predicted 0x%0h",
                     reply_no, field, seen, want);
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        int     k;
        if (!i_rst_n) begin
            board_count = 0;
            for (k = 0; k < ENTRIES; k++) begin
                board_score[k] = '0;
                board_tag[k]   = '0;
            end
            replies_due.delete();
        end else begin
            if (i_start && !i_busy)
                replies_due.push_back(rank_request(i_mode, i_player_tag, i_new_score,
                                                   i_read_index));
            if (i_strobe) begin
                if (replies_due.size() == 0) begin
                    note_mismatch("result with no request outstanding", 1, 0);
                end else begin
                    want = replies_due.pop_front();
                    if (i_inserted !== want.inserted)
                        note_mismatch("inserted", i_inserted, want.inserted);
                    if (i_insert_position !== want.position)
                        note_mismatch("insert_position", i_insert_position, want.position);
                    if (i_entry_count !== want.count)
                        note_mismatch("entry_count", i_entry_count, want.count);
                    if (i_read_valid !== want.read_valid)
                        note_mismatch("read_valid", i_read_valid, want.read_valid);
                    if (i_read_tag !== want.read_tag)
                        note_mismatch("read_tag", i_read_tag, want.read_tag);
                    if (i_read_score !== want.read_score)
                        note_mismatch("read_score", i_read_score, want.read_score);
                end
                reply_no++;
            end
        end
        o_fail_count  <= fail_total;
        o_replies_due <= replies_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// drives the score table with directed inserts and reads (ties, extremes,
// full-table drops, reads past the count), then random requests with idle
// gaps, and gives the verdict from the checker's failure count
// ---------------------------------------------------------------------------
module tb_top
    import tnsi_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_COUNT = 1050;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_mode;
    logic [TAG_BITS-1:0]          i_player_tag;
    logic signed [SCORE_BITS-1:0] i_new_score;
    logic [IDX_BITS-1:0]          i_read_index;
    logic                         o_strobe;
    logic                         o_inserted;
    logic [IDX_BITS-1:0]          o_insert_position;
    logic [CNT_BITS-1:0]          o_entry_count;
    logic                         o_read_valid;
    logic [TAG_BITS-1:0]          o_read_tag;
    logic signed [SCORE_BITS-1:0] o_read_score;

    int                           fail_count;
    int                           replies_due;
    int                           cycles;
    int                           n_inserts;
    int                           n_reads;
    logic signed [SCORE_BITS-1:0] recent_scores [$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    top_n_sorted_insert uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_player_tag      (i_player_tag),
        .i_new_score       (i_new_score),
        .i_read_index      (i_read_index),
        .o_strobe          (o_strobe),
        .o_inserted        (o_inserted),
        .o_insert_position (o_insert_position),
        .o_entry_count     (o_entry_count),
        .o_read_valid      (o_read_valid),
        .o_read_tag        (o_read_tag),
        .o_read_score      (o_read_score)
    );

    tnsi_score_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_mode            (i_mode),
        .i_player_tag      (i_player_tag),
        .i_new_score       (i_new_score),
        .i_read_index      (i_read_index),
        .i_strobe          (o_strobe),
        .i_inserted        (o_inserted),
        .i_insert_position (o_insert_position),
        .i_entry_count     (o_entry_count),
        .i_read_valid      (o_read_valid),
        .i_read_tag        (o_read_tag),
        .i_read_score      (o_read_score),
        .o_fail_count      (fail_count),
        .o_replies_due     (replies_due)
    );

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, replies_due);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold the request until the table takes it
    task automatic issue(input logic                         mode,
                         input logic [TAG_BITS-1:0]          tag,
                         input logic signed [SCORE_BITS-1:0] score,
                         input logic [IDX_BITS-1:0]          idx);
        start        <= 1'b1;
        i_mode       <= mode;
        i_player_tag <= tag;
        i_new_score  <= score;
        i_read_index <= idx;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (mode == MODE_INSERT) begin
            n_inserts++;
            recent_scores.push_back(score);
            if (recent_scores.size() > ENTRIES)
                void'(recent_scores.pop_front());
        end else begin
            n_reads++;
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic signed [SCORE_BITS-1:0] score;
        logic signed [SCORE_BITS-1:0] climb;
        int                           kind;
        int                           n;
        bit                           quiet;
        n_inserts    = 0;
        n_reads      = 0;
        climb        = 32'sh7000_0000;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_INSERT;
        i_player_tag <= '0;
        i_new_score  <= '0;
        i_read_index <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, ties in arrival order, extremes, full-table drops
        issue(MODE_READ,   16'h0000, 0, 3'd0);
        issue(MODE_READ,   16'h0000, 0, 3'd7);
        issue(MODE_INSERT, 16'h0001, 0, 3'd0);
        issue(MODE_INSERT, 16'h0002, 0, 3'd7);
        issue(MODE_READ,   16'h0000, 0, 3'd1);
        issue(MODE_READ,   16'h0000, 0, 3'd2);
        issue(MODE_INSERT, 16'hffff, SCORE_MAX, 3'd0);
        issue(MODE_INSERT, 16'h0000, SCORE_MIN, 3'd0);
        issue(MODE_INSERT, 16'h5555, -1, 3'd0);
        issue(MODE_INSERT, 16'haaaa, 1, 3'd0);
        issue(MODE_INSERT, 16'h0003, 100, 3'd0);
        issue(MODE_INSERT, 16'h0004, -100, 3'd0);
        issue(MODE_INSERT, 16'h0005, SCORE_MIN, 3'd0);
        issue(MODE_INSERT, 16'h0006, 50, 3'd0);
        issue(MODE_INSERT, 16'h0007, -200, 3'd0);
        issue(MODE_INSERT, 16'h0008, SCORE_MAX, 3'd0);
        for (n = 0; n < ENTRIES; n++)
            issue(MODE_READ, 16'h0000, 0, IDX_BITS'(n));
        hold_until_drained();

        for (n = 0; n < RANDOM_COUNT; n++) begin
            quiet = (n >= 400 && n < 600);
            if (n == 700)
                hold_until_drained();
            if ($urandom_range(0, 99) < 45) begin
                issue(MODE_READ, TAG_BITS'($urandom), SCORE_BITS'($urandom),
                      IDX_BITS'($urandom_range(0, ENTRIES - 1)));
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    score = SCORE_BITS'($urandom);
                end else if (kind < 35) begin
                    score = recent_scores[$urandom_range(0, recent_scores.size() - 1)];
                end else if (kind < 60) begin
                    score = recent_scores[$urandom_range(0, recent_scores.size() - 1)]
                            + SCORE_BITS'($urandom_range(0, 8)) - SCORE_BITS'(4);
                end else if (kind < 64) begin
                    case ($urandom_range(0, 7))
                        0:       score = SCORE_MAX;
                        1, 2:    score = SCORE_MIN;
                        3, 4:    score = '0;
                        default: score = -1;
                    endcase
                end else begin
                    climb = climb + SCORE_BITS'($urandom_range(1, 4096));
                    score = climb;
                end
                issue(MODE_INSERT, TAG_BITS'($urandom), score,
                      IDX_BITS'($urandom_range(0, ENTRIES - 1)));
            end
            if (!quiet && $urandom_range(0, 99) < 19) begin
                start <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 3))
                    @(posedge i_clk);
            end
        end

        hold_until_drained();
        repeat (4) @(posedge i_clk);
        $display("run covered %0d insert and %0d read requests on a %0d-entry table",
                 n_inserts, n_reads, ENTRIES);
        $display("including ties, extreme scores, full-table drops and reads past the count");
        if (fail_count == 0 && replies_due == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/tnsi_pkg.sv
design/tnsi_cell.sv
design/top_n_sorted_insert.sv
dv/tnsi_score_checker.sv
dv/tb_top.sv
